// ===== design/mts_pkg.sv =====
package mts_pkg;

  localparam int unsigned DEPTH = 256;

  localparam int unsigned DATA_W = 32;

  // request kinds
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // value reported for top and max when the stack is empty
  localparam logic signed [DATA_W-1:0] EMPTY_WORD = -32'sd1;

  typedef struct packed {
    logic push;  // apply a push request (or flag overflow when full)
    logic pop;   // apply a pop request
    logic fill;  // load the new top from the memory read data
  } cmd_t;

  typedef struct packed {
    logic needs_read;  // a pop now would leave entries that live in memory
  } status_t;

endpackage

// ===== design/mts_ctrl.sv =====
module mts_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             req_type_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  mts_pkg::status_t status_i,
  output mts_pkg::cmd_t    cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WAIT = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept;
  logic load_out;

  // output slot is free if empty or being drained this cycle
  assign in_stall_o = (state_q == ST_WAIT) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_type_i == mts_pkg::REQ_PUSH) begin
            cmd_o.push = 1'b1;
          end else begin
            cmd_o.pop = 1'b1;
            if (status_i.needs_read) begin
              state_d = ST_WAIT;
            end
          end
        end
      end
      ST_WAIT: begin
        cmd_o.fill = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign load_out = cmd_o.push || cmd_o.fill || (cmd_o.pop && !status_i.needs_read);

  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_pop_read_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.pop && status_i.needs_read) |=> (state_q == ST_WAIT && !out_valid_q))
    else $error("pop needing a read did not enter wait");
  a_wait_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAIT) |=> (state_q == ST_IDLE && out_valid_q))
    else $error("wait state did not produce an item");
  a_push_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |=> out_valid_q)
    else $error("push did not produce an item");
`endif

endmodule

// ===== design/mts_datapath.sv =====
module mts_datapath #(
  parameter int unsigned DEPTH = mts_pkg::DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mts_pkg::cmd_t                       cmd_i,
  output mts_pkg::status_t                    status_o,
  input  logic signed [mts_pkg::DATA_W-1:0]   push_value_i,
  output logic signed [mts_pkg::DATA_W-1:0]   top_value_o,
  output logic signed [mts_pkg::DATA_W-1:0]   current_max_o,
  output logic                                is_empty_o,
  output logic                                overflow_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned DW = mts_pkg::DATA_W;

  // entry: {max at or below, value}
  logic [2*DW-1:0] mem [DEPTH];
  logic [2*DW-1:0] rd_q;

  logic [CW-1:0] count_q, count_d;
  logic signed [DW-1:0] top_val_q, top_val_d;
  logic signed [DW-1:0] top_max_q, top_max_d;
  logic signed [DW-1:0] out_val_q, out_val_d;
  logic signed [DW-1:0] out_max_q, out_max_d;
  logic out_empty_q, out_empty_d;
  logic out_ovf_q, out_ovf_d;

  logic full, empty;
  logic signed [DW-1:0] new_max;
  logic [CW-1:0] count_dec;
  logic [CW-1:0] rd_idx;
  logic wr_en, rd_en;

  assign full      = (count_q == CW'(DEPTH));
  assign empty     = (count_q == '0);
  assign count_dec = count_q - CW'(1);
  assign rd_idx    = count_q - CW'(2);
  assign status_o.needs_read = (count_q > CW'(1));

  assign new_max = (!empty && (top_max_q > push_value_i)) ? top_max_q : push_value_i;
  assign wr_en   = cmd_i.push && !full;
  assign rd_en   = cmd_i.pop && status_o.needs_read;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[AW-1:0]] <= {new_max, push_value_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[rd_idx[AW-1:0]];
    end
  end

  always_comb begin
    count_d     = count_q;
    top_val_d   = top_val_q;
    top_max_d   = top_max_q;
    out_val_d   = out_val_q;
    out_max_d   = out_max_q;
    out_empty_d = out_empty_q;
    out_ovf_d   = out_ovf_q;
    if (cmd_i.push) begin
      out_empty_d = 1'b0;
      if (full) begin
        out_val_d = top_val_q;
        out_max_d = top_max_q;
        out_ovf_d = 1'b1;
      end else begin
        count_d   = count_q + CW'(1);
        top_val_d = push_value_i;
        top_max_d = new_max;
        out_val_d = push_value_i;
        out_max_d = new_max;
        out_ovf_d = 1'b0;
      end
    end else if (cmd_i.pop) begin
      if (!empty) begin
        count_d = count_dec;
      end
      if (!status_o.needs_read) begin
        // stack is empty after this pop
        out_val_d   = mts_pkg::EMPTY_WORD;
        out_max_d   = mts_pkg::EMPTY_WORD;
        out_empty_d = 1'b1;
        out_ovf_d   = 1'b0;
      end
    end else if (cmd_i.fill) begin
      top_val_d   = rd_q[DW-1:0];
      top_max_d   = rd_q[2*DW-1:DW];
      out_val_d   = rd_q[DW-1:0];
      out_max_d   = rd_q[2*DW-1:DW];
      out_empty_d = 1'b0;
      out_ovf_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_val_q   <= top_val_d;
    top_max_q   <= top_max_d;
    out_val_q   <= out_val_d;
    out_max_q   <= out_max_d;
    out_empty_q <= out_empty_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign top_value_o   = out_val_q;
  assign current_max_o = out_max_q;
  assign is_empty_o    = out_empty_q;
  assign overflow_o    = out_ovf_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count beyond depth");
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |=> (count_q == ($past(full) ? $past(count_q) : $past(count_q) + CW'(1))))
    else $error("push did not update count");
`endif

endmodule

// ===== design/max_tracking_stack.sv =====
// Max-tracking LIFO stack of signed 32-bit values.
// Input channel: in_valid_i / in_stall_o with req_type_i (0 push, 1 pop)
// and push_value_i. Output channel: out_valid_o / out_stall_i with
// top_value_o, current_max_o, is_empty_o and overflow_o; one item out per
// item in, in order. Top and max read -1 when the stack is empty.
// Latency: a push, an overflowing push, or a pop that empties the stack or
// finds it empty delivers its result on the next cycle. A pop that leaves at
// least one entry first does a registered read of the new top from the entry
// memory (one write and one read port), then loads the output; in_stall_o
// is high meanwhile. Pushes sustain one per cycle while out_stall_i is low.
// A push onto a full stack (DEPTH entries) is dropped and reported with
// overflow_o set and the unchanged top. A pop on an empty stack reports
// empty. The top entry is cached in registers, the memory holds all entries.
// Reset empties the stack at once (count cleared); no clearing pass.
// While out_stall_i holds a result, in_stall_o stays high unless the
// result is taken in the same cycle, so nothing is lost or overwritten.
module max_tracking_stack #(
  parameter int unsigned DEPTH = mts_pkg::DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              req_type_i,
  input  logic signed [mts_pkg::DATA_W-1:0] push_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [mts_pkg::DATA_W-1:0] top_value_o,
  output logic signed [mts_pkg::DATA_W-1:0] current_max_o,
  output logic                              is_empty_o,
  output logic                              overflow_o
);

  mts_pkg::cmd_t    cmd;
  mts_pkg::status_t status;

  mts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mts_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .push_value_i  (push_value_i),
    .top_value_o   (top_value_o),
    .current_max_o (current_max_o),
    .is_empty_o    (is_empty_o),
    .overflow_o    (overflow_o)
  );

endmodule
